// ----- rtl/dnes_pkg.sv -----
`default_nettype none

package dnes_pkg;

  localparam int CELL_W     = 9;
  localparam int COORD_W    = 8;
  localparam int MAPW_W     = 6;
  localparam int DIST_W     = 18;
  localparam int DIV_STAGES = 3;
  localparam int DIV_STEP   = 3;

  localparam logic [1:0] REQ_INSERT = 2'd0;
  localparam logic [1:0] REQ_REMOVE = 2'd1;
  localparam logic [1:0] REQ_QUERY  = 2'd2;

  localparam logic [2:0] HEAD_ANY   = 3'd0;
  localparam logic [2:0] HEAD_UP    = 3'd1;
  localparam logic [2:0] HEAD_DOWN  = 3'd2;
  localparam logic [2:0] HEAD_LEFT  = 3'd3;
  localparam logic [2:0] HEAD_RIGHT = 3'd4;

  localparam logic [1:0] CFG_X_OFFSET  = 2'd0;
  localparam logic [1:0] CFG_Y_OFFSET  = 2'd1;
  localparam logic [1:0] CFG_MAP_WIDTH = 2'd2;

  typedef struct packed {
    logic              vld;
    logic              last;
    logic [CELL_W-1:0] entry;
  } tag_t;

  typedef struct packed {
    logic              vld;
    logic              last;
    logic              ok;
    logic [CELL_W-1:0] entry;
    logic [DIST_W-1:0] sq_dist;
  } hit_t;

endpackage

`default_nettype wire

// ----- rtl/dnes_entry_mem.sv -----
`default_nettype none

module dnes_entry_mem
  import dnes_pkg::*;
#(
  parameter int DEPTH = 32,
  parameter int AW    = 5
) (
  input  wire logic              clk,
  input  wire logic              we,
  input  wire logic [AW-1:0]     waddr,
  input  wire logic [CELL_W-1:0] wdata,
  input  wire logic              re,
  input  wire logic [AW-1:0]     raddr,
  output      logic [CELL_W-1:0] rdata
);

  logic [CELL_W-1:0] mem_r [DEPTH];
  logic [CELL_W-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (re) begin
      rdata_r <= mem_r[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

`default_nettype wire

// ----- rtl/dnes_divmod.sv -----
`default_nettype none

module dnes_divmod
  import dnes_pkg::*;
(
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire tag_t              in_tag,
  input  wire logic [MAPW_W-1:0] divisor,
  output      tag_t              out_tag,
  output      logic [CELL_W-1:0] out_quot,
  output      logic [MAPW_W-1:0] out_rem
);

  tag_t              tag_q [DIV_STAGES];
  logic [MAPW_W-1:0] rem_q [DIV_STAGES];
  logic [CELL_W-1:0] num_q [DIV_STAGES];

  for (genvar s = 0; s < DIV_STAGES; s++) begin : g_stage
    tag_t              tag_src;
    logic [MAPW_W-1:0] rem_src;
    logic [CELL_W-1:0] num_src;
    logic [MAPW_W-1:0] rem_c;
    logic [CELL_W-1:0] num_c;
    logic [MAPW_W:0]   trial;

    if (s == 0) begin : g_first
      assign tag_src = in_tag;
      assign rem_src = '0;
      assign num_src = in_tag.entry;
    end else begin : g_next
      assign tag_src = tag_q[s-1];
      assign rem_src = rem_q[s-1];
      assign num_src = num_q[s-1];
    end

    // restoring division, quotient bits shift in from the bottom
    always_comb begin
      rem_c = rem_src;
      num_c = num_src;
      trial = '0;
      for (int b = 0; b < DIV_STEP; b++) begin
        trial = {rem_c, num_c[CELL_W-1]};
        if (trial >= {1'b0, divisor}) begin
          trial = trial - {1'b0, divisor};
          num_c = {num_c[CELL_W-2:0], 1'b1};
        end else begin
          num_c = {num_c[CELL_W-2:0], 1'b0};
        end
        rem_c = trial[MAPW_W-1:0];
      end
    end

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        tag_q[s] <= '0;
      end else begin
        tag_q[s] <= tag_src;
      end
    end

    always_ff @(posedge clk) begin
      rem_q[s] <= rem_c;
      num_q[s] <= num_c;
    end
  end

  assign out_tag  = tag_q[DIV_STAGES-1];
  assign out_quot = num_q[DIV_STAGES-1];
  assign out_rem  = rem_q[DIV_STAGES-1];

endmodule

`default_nettype wire

// ----- rtl/dnes_dist_pipe.sv -----
`default_nettype none

module dnes_dist_pipe
  import dnes_pkg::*;
#(
  parameter int TILE_W   = 4,
  parameter int TILE_H   = 16,
  parameter int PX_PER_B = 8
) (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire tag_t               in_tag,
  input  wire logic [COORD_W-1:0] x_offset,
  input  wire logic [COORD_W-1:0] y_offset,
  input  wire logic [MAPW_W-1:0]  map_width,
  input  wire logic [COORD_W-1:0] origin_x,
  input  wire logic [COORD_W-1:0] origin_y_px,
  input  wire logic [2:0]         heading,
  output      hit_t               hit
);

  // exact for 8-bit dividends: error below 1/256, fraction gap at least 1/16
  localparam int RECIP  = (65536 + PX_PER_B - 1) / PX_PER_B;
  localparam int PROD_W = COORD_W + 17;

  logic [MAPW_W-1:0] divisor;
  tag_t              div_tag;
  logic [CELL_W-1:0] div_quot;
  logic [MAPW_W-1:0] div_rem;

  assign divisor = (map_width == '0) ? MAPW_W'(1) : map_width;

  dnes_divmod u_divmod (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_tag  (in_tag),
    .divisor (divisor),
    .out_tag (div_tag),
    .out_quot(div_quot),
    .out_rem (div_rem)
  );

  // stage 1: column and row to screen x and pixel y
  tag_t               c1_tag_r;
  logic [COORD_W-1:0] c1_x_r;
  logic [COORD_W-1:0] c1_ypx_r;
  logic [15:0]        col_scaled;
  logic [15:0]        row_scaled;

  assign col_scaled = 16'(div_rem) * 16'(TILE_W);
  assign row_scaled = 16'(div_quot) * 16'(TILE_H);

  // stage 2: pixel y to byte rows
  tag_t               c2_tag_r;
  logic [COORD_W-1:0] c2_x_r;
  logic [COORD_W-1:0] c2_y_r;
  logic [COORD_W-1:0] oy_r;
  logic [PROD_W-1:0]  y_prod;
  logic [PROD_W-1:0]  oy_prod;

  assign y_prod  = PROD_W'(c1_ypx_r) * PROD_W'(RECIP);
  assign oy_prod = PROD_W'(origin_y_px) * PROD_W'(RECIP);

  // stage 3: direction filter and deltas
  tag_t               c3_tag_r;
  logic               c3_ok_r;
  logic [COORD_W-1:0] c3_dx_r;
  logic [COORD_W-1:0] c3_dy_r;
  logic               ok_c;
  logic [COORD_W-1:0] dx_c;
  logic [COORD_W-1:0] dy_c;

  always_comb begin
    unique case (heading)
      HEAD_ANY:   ok_c = 1'b1;
      HEAD_UP:    ok_c = c2_y_r < oy_r;
      HEAD_DOWN:  ok_c = c2_y_r > oy_r;
      HEAD_LEFT:  ok_c = c2_x_r < origin_x;
      HEAD_RIGHT: ok_c = c2_x_r > origin_x;
      default:    ok_c = 1'b0;
    endcase
    dx_c = (origin_x > c2_x_r) ? (origin_x - c2_x_r) : (c2_x_r - origin_x);
    dy_c = (oy_r > c2_y_r) ? (oy_r - c2_y_r) : (c2_y_r - oy_r);
  end

  // stage 4: squared distance
  hit_t              c4_hit_r;
  logic [DIST_W-1:0] dist_c;

  assign dist_c = DIST_W'(c3_dx_r) * DIST_W'(c3_dx_r) + DIST_W'(c3_dy_r) * DIST_W'(c3_dy_r);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      c1_tag_r     <= '0;
      c2_tag_r     <= '0;
      c3_tag_r     <= '0;
      c4_hit_r.vld <= 1'b0;
    end else begin
      c1_tag_r     <= div_tag;
      c2_tag_r     <= c1_tag_r;
      c3_tag_r     <= c2_tag_r;
      c4_hit_r.vld <= c3_tag_r.vld;
    end
    c1_x_r           <= x_offset + col_scaled[COORD_W-1:0];
    c1_ypx_r         <= y_offset + row_scaled[COORD_W-1:0];
    c2_x_r           <= c1_x_r;
    c2_y_r           <= y_prod[16 +: COORD_W];
    oy_r             <= oy_prod[16 +: COORD_W];
    c3_ok_r          <= ok_c;
    c3_dx_r          <= dx_c;
    c3_dy_r          <= dy_c;
    c4_hit_r.last    <= c3_tag_r.last;
    c4_hit_r.ok      <= c3_ok_r;
    c4_hit_r.entry   <= c3_tag_r.entry;
    c4_hit_r.sq_dist <= dist_c;
  end

  assign hit = c4_hit_r;

endmodule

`default_nettype wire

// ----- rtl/directional_nearest_entry_search_top.sv -----
`default_nettype none

// insert and unknown requests: the request is captured, then the execute state raises the registered result strobe
// remove: the table is scanned for the cell; on a match the later entries are shifted down one slot
// query: one read per cycle into a 7-stage pipeline; an empty table answers straight from the execute state
// one request at a time; busy drops in the cycle the result strobe shows
// results are never held off, each strobe lasts exactly one cycle
// synchronous reset clears count and config; table contents stay undefined until written
module directional_nearest_entry_search_top
  import dnes_pkg::*;
#(
  parameter int MAX_ENTRIES = 32,
  parameter int TILE_W      = 4,
  parameter int TILE_H      = 16,
  parameter int PX_PER_B    = 8
) (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               start,
  output      logic               busy,
  input  wire logic [1:0]         in_req_type,
  input  wire logic [CELL_W-1:0]  in_cell_index,
  input  wire logic [COORD_W-1:0] in_origin_x,
  input  wire logic [COORD_W-1:0] in_origin_y_px,
  input  wire logic [2:0]         in_heading,
  output      logic               out_strobe,
  output      logic               out_found,
  output      logic [CELL_W-1:0]  out_nearest_cell,
  output      logic               out_table_full,
  output      logic [5:0]         out_entry_count,
  input  wire logic               cfg_we,
  input  wire logic [1:0]         cfg_index,
  input  wire logic [7:0]         cfg_wdata
);

  localparam int CW = $clog2(MAX_ENTRIES + 1);
  localparam int AW = (MAX_ENTRIES > 1) ? $clog2(MAX_ENTRIES) : 1;
  localparam logic [CW-1:0] MAX_CNT = CW'(MAX_ENTRIES);

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_EXEC,
    ST_RM_SCAN,
    ST_RM_SHIFT,
    ST_QUERY
  } state_t;

  state_t             state_r;
  logic [COORD_W-1:0] x_offset_r;
  logic [COORD_W-1:0] y_offset_r;
  logic [MAPW_W-1:0]  map_width_r;

  logic [1:0]         req_r;
  logic [CELL_W-1:0]  cell_r;
  logic [COORD_W-1:0] ox_r;
  logic [COORD_W-1:0] oy_px_r;
  logic [2:0]         head_r;

  logic [CW-1:0]      count_r;
  logic [CW-1:0]      ptr_r;
  logic               pend_r;
  logic [AW-1:0]      pend_idx_r;
  logic               pend_last_r;

  logic               found_r;
  logic [CELL_W-1:0]  near_r;
  logic [DIST_W-1:0]  best_r;

  logic               out_strobe_r;
  logic               out_found_r;
  logic [CELL_W-1:0]  out_near_r;
  logic               out_full_r;
  logic [5:0]         out_count_r;

  logic               issue;
  logic               mem_we;
  logic [AW-1:0]      mem_waddr;
  logic [CELL_W-1:0]  mem_wdata;
  logic [CELL_W-1:0]  mem_rdata;
  tag_t               pipe_tag;
  hit_t               hit;
  logic               take;
  logic               found_nxt;
  logic [CELL_W-1:0]  near_nxt;
  logic [DIST_W-1:0]  best_nxt;

  assign busy = (state_r != ST_IDLE);

  assign issue = ((state_r == ST_RM_SCAN) || (state_r == ST_RM_SHIFT) ||
                  (state_r == ST_QUERY)) && (ptr_r < count_r);

  always_comb begin
    mem_we    = 1'b0;
    mem_waddr = pend_idx_r - AW'(1);
    mem_wdata = mem_rdata;
    if (state_r == ST_EXEC) begin
      mem_we    = (req_r == REQ_INSERT) && (count_r < MAX_CNT);
      mem_waddr = count_r[AW-1:0];
      mem_wdata = cell_r;
    end else if (state_r == ST_RM_SHIFT) begin
      mem_we = pend_r;
    end
  end

  dnes_entry_mem #(
    .DEPTH(MAX_ENTRIES),
    .AW   (AW)
  ) u_entry_mem (
    .clk  (clk),
    .we   (mem_we),
    .waddr(mem_waddr),
    .wdata(mem_wdata),
    .re   (issue),
    .raddr(ptr_r[AW-1:0]),
    .rdata(mem_rdata)
  );

  assign pipe_tag.vld   = pend_r && (state_r == ST_QUERY);
  assign pipe_tag.last  = pend_last_r;
  assign pipe_tag.entry = mem_rdata;

  dnes_dist_pipe #(
    .TILE_W  (TILE_W),
    .TILE_H  (TILE_H),
    .PX_PER_B(PX_PER_B)
  ) u_dist_pipe (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tag     (pipe_tag),
    .x_offset   (x_offset_r),
    .y_offset   (y_offset_r),
    .map_width  (map_width_r),
    .origin_x   (ox_r),
    .origin_y_px(oy_px_r),
    .heading    (head_r),
    .hit        (hit)
  );

  // earlier entry wins a tie
  assign take      = hit.vld && hit.ok && (!found_r || (hit.sq_dist < best_r));
  assign found_nxt = found_r || take;
  assign near_nxt  = take ? hit.entry : near_r;
  assign best_nxt  = take ? hit.sq_dist : best_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      x_offset_r  <= '0;
      y_offset_r  <= '0;
      map_width_r <= MAPW_W'(1);
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_X_OFFSET:  x_offset_r  <= cfg_wdata;
        CFG_Y_OFFSET:  y_offset_r  <= cfg_wdata;
        CFG_MAP_WIDTH: map_width_r <= cfg_wdata[MAPW_W-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= ST_IDLE;
      count_r      <= '0;
      ptr_r        <= '0;
      pend_r       <= 1'b0;
      found_r      <= 1'b0;
      out_strobe_r <= 1'b0;
    end else begin
      out_strobe_r <= 1'b0;
      unique case (state_r)
        ST_IDLE: begin
          if (start) begin
            req_r   <= in_req_type;
            cell_r  <= in_cell_index;
            ox_r    <= in_origin_x;
            oy_px_r <= in_origin_y_px;
            head_r  <= in_heading;
            state_r <= ST_EXEC;
          end
        end
        ST_EXEC: begin
          ptr_r       <= '0;
          pend_r      <= 1'b0;
          found_r     <= 1'b0;
          near_r      <= '0;
          best_r      <= '0;
          out_found_r <= 1'b0;
          out_near_r  <= '0;
          out_full_r  <= 1'b0;
          out_count_r <= 6'(count_r);
          unique case (req_r)
            REQ_INSERT: begin
              if (count_r < MAX_CNT) begin
                count_r     <= count_r + CW'(1);
                out_count_r <= 6'(count_r + CW'(1));
              end else begin
                out_full_r <= 1'b1;
              end
              out_strobe_r <= 1'b1;
              state_r      <= ST_IDLE;
            end
            REQ_REMOVE: begin
              state_r <= ST_RM_SCAN;
            end
            REQ_QUERY: begin
              if (count_r == '0) begin
                out_strobe_r <= 1'b1;
                state_r      <= ST_IDLE;
              end else begin
                state_r <= ST_QUERY;
              end
            end
            default: begin
              out_strobe_r <= 1'b1;
              state_r      <= ST_IDLE;
            end
          endcase
        end
        ST_RM_SCAN: begin
          if (issue) begin
            ptr_r <= ptr_r + CW'(1);
          end
          pend_r     <= issue;
          pend_idx_r <= ptr_r[AW-1:0];
          if (pend_r && (mem_rdata == cell_r)) begin
            state_r <= ST_RM_SHIFT;
          end else if (!pend_r && !issue) begin
            out_found_r  <= 1'b0;
            out_count_r  <= 6'(count_r);
            out_strobe_r <= 1'b1;
            state_r      <= ST_IDLE;
          end
        end
        ST_RM_SHIFT: begin
          // each read entry moves down one slot
          if (issue) begin
            ptr_r <= ptr_r + CW'(1);
          end
          pend_r     <= issue;
          pend_idx_r <= ptr_r[AW-1:0];
          if (!pend_r && !issue) begin
            count_r      <= count_r - CW'(1);
            out_found_r  <= 1'b1;
            out_count_r  <= 6'(count_r - CW'(1));
            out_strobe_r <= 1'b1;
            state_r      <= ST_IDLE;
          end
        end
        ST_QUERY: begin
          if (issue) begin
            ptr_r <= ptr_r + CW'(1);
          end
          pend_r      <= issue;
          pend_last_r <= (ptr_r + CW'(1)) == count_r;
          found_r     <= found_nxt;
          near_r      <= near_nxt;
          best_r      <= best_nxt;
          if (hit.vld && hit.last) begin
            out_found_r  <= found_nxt;
            out_near_r   <= near_nxt;
            out_count_r  <= 6'(count_r);
            out_strobe_r <= 1'b1;
            state_r      <= ST_IDLE;
          end
        end
        default: begin
          state_r <= ST_IDLE;
        end
      endcase
    end
  end

  assign out_strobe       = out_strobe_r;
  assign out_found        = out_found_r;
  assign out_nearest_cell = out_near_r;
  assign out_table_full   = out_full_r;
  assign out_entry_count  = out_count_r;

endmodule

`default_nettype wire

// ----- dv/nearest_search_checker.sv -----
module nearest_search_checker
  import dnes_pkg::*;
#(
  parameter int TABLE_DEPTH = 32,
  parameter int COL_STEP    = 4,
  parameter int ROW_STEP    = 16,
  parameter int PX_PER_BYTE = 8
) (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               start,
  input  wire logic               busy,
  input  wire logic [1:0]         in_req_type,
  input  wire logic [CELL_W-1:0]  in_cell_index,
  input  wire logic [COORD_W-1:0] in_origin_x,
  input  wire logic [COORD_W-1:0] in_origin_y_px,
  input  wire logic [2:0]         in_heading,
  input  wire logic               out_strobe,
  input  wire logic               out_found,
  input  wire logic [CELL_W-1:0]  out_nearest_cell,
  input  wire logic               out_table_full,
  input  wire logic [5:0]         out_entry_count,
  input  wire logic               cfg_we,
  input  wire logic [1:0]         cfg_index,
  input  wire logic [7:0]         cfg_wdata,
  output int                      errors,
  output int                      pending
);

  typedef struct packed {
    logic              found;
    logic [CELL_W-1:0] near_cell;
    logic              full;
    logic [5:0]        count;
  } answer_t;

  answer_t           owed_answers[$];
  logic [CELL_W-1:0] table_cells[TABLE_DEPTH];
  int                table_len = 0;
  logic [7:0]        x_off = 8'd0;
  logic [7:0]        y_off = 8'd0;
  logic [5:0]        map_w = 6'd1;
  int                err_count = 0;

  initial begin
    errors  = 0;
    pending = 0;
  end

  function automatic answer_t answer_request(input logic [1:0] req,
                                             input logic [CELL_W-1:0] cell_idx,
                                             input logic [COORD_W-1:0] ox,
                                             input logic [COORD_W-1:0] oy_px,
                                             input logic [2:0] hd);
    answer_t ans;
    int      pos;
    int      w;
    int      tx;
    int      ty;
    int      oy;
    int      dx;
    int      dy;
    int      d;
    int      best;
    bit      ok;
    ans  = '0;
    best = 0;
    pos  = -1;
    if (req == REQ_INSERT) begin
      if (table_len >= TABLE_DEPTH) begin
        ans.full = 1'b1;
      end else begin
        table_cells[table_len] = cell_idx;
        table_len++;
      end
    end else if (req == REQ_REMOVE) begin
      for (int i = 0; i < table_len; i++) begin
        if (pos < 0 && table_cells[i] == cell_idx) pos = i;
      end
      if (pos >= 0) begin
        for (int j = pos; j + 1 < table_len; j++) table_cells[j] = table_cells[j + 1];
        table_len--;
        ans.found = 1'b1;
      end
    end else if (req == REQ_QUERY) begin
      w  = (map_w == 6'd0) ? 1 : int'(map_w);
      oy = int'(oy_px) / PX_PER_BYTE;
      for (int i = 0; i < table_len; i++) begin
        tx = (int'(x_off) + (int'(table_cells[i]) % w) * COL_STEP) & 255;
        ty = ((int'(y_off) + (int'(table_cells[i]) / w) * ROW_STEP) & 255) / PX_PER_BYTE;
        case (hd)
          HEAD_ANY:   ok = 1'b1;
          HEAD_UP:    ok = ty < oy;
          HEAD_DOWN:  ok = ty > oy;
          HEAD_LEFT:  ok = tx < int'(ox);
          HEAD_RIGHT: ok = tx > int'(ox);
          default:    ok = 1'b0;
        endcase
        if (ok) begin
          dx = tx - int'(ox);
          dy = ty - oy;
          d  = dx * dx + dy * dy;
          if (!ans.found || d < best) begin
            ans.found     = 1'b1;
            ans.near_cell = table_cells[i];
            best          = d;
          end
        end
      end
    end
    ans.count = table_len[5:0];
    return ans;
  endfunction

  function automatic void check_field(input string name, input int want, input int got);
    if (want != got) begin
      $error("%s: expected %0d, got %0d", name, want, got);
      err_count++;
    end
  endfunction

  always @(posedge clk) begin
    answer_t want;
    if (!rst_n) begin
      table_len = 0;
      x_off     = 8'd0;
      y_off     = 8'd0;
      map_w     = 6'd1;
      owed_answers.delete();
    end else begin
      if (out_strobe) begin
        if (owed_answers.size() == 0) begin
          $error("result with no request waiting: found %0d cell %0d full %0d count %0d",
                 out_found, out_nearest_cell, out_table_full, out_entry_count);
          err_count++;
        end else begin
          want = owed_answers.pop_front();
          check_field("found", int'(want.found), int'(out_found));
          check_field("nearest_cell", int'(want.near_cell), int'(out_nearest_cell));
          check_field("table_full", int'(want.full), int'(out_table_full));
          check_field("entry_count", int'(want.count), int'(out_entry_count));
        end
      end
      if (cfg_we) begin
        case (cfg_index)
          CFG_X_OFFSET:  x_off = cfg_wdata;
          CFG_Y_OFFSET:  y_off = cfg_wdata;
          CFG_MAP_WIDTH: map_w = cfg_wdata[5:0];
          default: ;
        endcase
      end
      if (start && !busy) begin
        owed_answers.push_back(answer_request(in_req_type, in_cell_index, in_origin_x,
                                              in_origin_y_px, in_heading));
      end
    end
    pending <= owed_answers.size();
    errors  <= err_count;
  end

endmodule

// ----- dv/tb.sv -----
module tb;
  import dnes_pkg::*;

  localparam int TABLE_DEPTH       = 32;
  localparam int COL_STEP          = 4;
  localparam int ROW_STEP          = 16;
  localparam int PX_PER_BYTE       = 8;
  localparam logic [1:0] REQ_UNKNOWN = 2'd3;
  localparam int STALL_LIMIT       = 4000;
  localparam int DRAIN_CYCLES      = 80;
  localparam int ITEMS_PER_SETTING = 122;

  logic               clk = 1'b0;
  logic               rst_n = 1'b0;
  logic               start = 1'b0;
  logic               busy;
  logic [1:0]         in_req_type = REQ_INSERT;
  logic [CELL_W-1:0]  in_cell_index = '0;
  logic [COORD_W-1:0] in_origin_x = '0;
  logic [COORD_W-1:0] in_origin_y_px = '0;
  logic [2:0]         in_heading = HEAD_ANY;
  logic               out_strobe;
  logic               out_found;
  logic [CELL_W-1:0]  out_nearest_cell;
  logic               out_table_full;
  logic [5:0]         out_entry_count;
  logic               cfg_we = 1'b0;
  logic [1:0]         cfg_index = CFG_X_OFFSET;
  logic [7:0]         cfg_wdata = 8'd0;
  int                 check_errors;
  int                 results_owed;
  int                 idle_cycles = 0;
  bit                 gaps_on = 1'b1;
  logic [CELL_W-1:0]  stored_cells[$];

  directional_nearest_entry_search_top #(
    .MAX_ENTRIES(TABLE_DEPTH),
    .TILE_W(COL_STEP),
    .TILE_H(ROW_STEP),
    .PX_PER_B(PX_PER_BYTE)
  ) dut (
    .clk(clk), .rst_n(rst_n), .start(start), .busy(busy),
    .in_req_type(in_req_type), .in_cell_index(in_cell_index),
    .in_origin_x(in_origin_x), .in_origin_y_px(in_origin_y_px), .in_heading(in_heading),
    .out_strobe(out_strobe), .out_found(out_found), .out_nearest_cell(out_nearest_cell),
    .out_table_full(out_table_full), .out_entry_count(out_entry_count),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_wdata(cfg_wdata)
  );

  nearest_search_checker #(
    .TABLE_DEPTH(TABLE_DEPTH),
    .COL_STEP(COL_STEP),
    .ROW_STEP(ROW_STEP),
    .PX_PER_BYTE(PX_PER_BYTE)
  ) result_check (
    .clk(clk), .rst_n(rst_n), .start(start), .busy(busy),
    .in_req_type(in_req_type), .in_cell_index(in_cell_index),
    .in_origin_x(in_origin_x), .in_origin_y_px(in_origin_y_px), .in_heading(in_heading),
    .out_strobe(out_strobe), .out_found(out_found), .out_nearest_cell(out_nearest_cell),
    .out_table_full(out_table_full), .out_entry_count(out_entry_count),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_wdata(cfg_wdata),
    .errors(check_errors), .pending(results_owed)
  );

  initial begin
    forever #10 clk = ~clk;
  end

  always @(posedge clk) begin
    if (!rst_n || (start && !busy) || out_strobe || cfg_we) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= STALL_LIMIT) begin
      $display("DONE: errors detected");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  task automatic send(input logic [1:0] req, input logic [CELL_W-1:0] cell_idx,
                      input logic [COORD_W-1:0] ox, input logic [COORD_W-1:0] oy,
                      input logic [2:0] hd);
    int pos;
    pos = -1;
    if (gaps_on && $urandom_range(0, 99) < 26) begin
      start <= 1'b0;
      repeat ($urandom_range(1, 6)) @(posedge clk);
    end
    start          <= 1'b1;
    in_req_type    <= req;
    in_cell_index  <= cell_idx;
    in_origin_x    <= ox;
    in_origin_y_px <= oy;
    in_heading     <= hd;
    @(posedge clk);
    while (busy) @(posedge clk);
    // shadow of the table contents, used only to aim removes at live cells
    if (req == REQ_INSERT && stored_cells.size() < TABLE_DEPTH) begin
      stored_cells.push_back(cell_idx);
    end else if (req == REQ_REMOVE) begin
      for (int i = 0; i < stored_cells.size(); i++) begin
        if (pos < 0 && stored_cells[i] == cell_idx) pos = i;
      end
      if (pos >= 0) stored_cells.delete(pos);
    end
  endtask

  task automatic set_config(input logic [7:0] xo, input logic [7:0] yo,
                            input logic [7:0] w);
    start <= 1'b0;
    @(posedge clk);
    while (results_owed != 0 || busy) @(posedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= CFG_X_OFFSET;
    cfg_wdata <= xo;
    @(posedge clk);
    cfg_index <= CFG_Y_OFFSET;
    cfg_wdata <= yo;
    @(posedge clk);
    cfg_index <= CFG_MAP_WIDTH;
    cfg_wdata <= w;
    @(posedge clk);
    cfg_we <= 1'b0;
  endtask

  task automatic random_request(input int ins_pct, input int rem_pct);
    int                pick;
    logic [1:0]        req;
    logic [CELL_W-1:0] cell_idx;
    logic [2:0]        hd;
    pick     = $urandom_range(0, 99);
    cell_idx = $urandom_range(0, 1) ? CELL_W'($urandom_range(0, 63))
                                    : CELL_W'($urandom_range(0, 511));
    hd       = ($urandom_range(0, 99) < 85) ? 3'($urandom_range(HEAD_ANY, HEAD_RIGHT))
                                            : 3'($urandom_range(HEAD_RIGHT + 1, 7));
    if (pick < 4) begin
      req = REQ_UNKNOWN;
    end else if (pick < 4 + ins_pct) begin
      req = REQ_INSERT;
    end else if (pick < 4 + ins_pct + rem_pct) begin
      req = REQ_REMOVE;
      if (stored_cells.size() > 0 && $urandom_range(0, 3) != 0) begin
        cell_idx = stored_cells[$urandom_range(0, stored_cells.size() - 1)];
      end
    end else begin
      req = REQ_QUERY;
    end
    send(req, cell_idx, COORD_W'($urandom_range(0, 255)), COORD_W'($urandom_range(0, 255)),
         hd);
  endtask

  initial begin
    logic [7:0] x_set[6];
    logic [7:0] y_set[6];
    logic [7:0] w_set[6];
    int         ins_set[6];
    int         rem_set[6];
    x_set   = '{8'd0, 8'd255, 8'd0, 8'd128, 8'd0, 8'd255};
    y_set   = '{8'd0, 8'd255, 8'd255, 8'd7, 8'd0, 8'd0};
    w_set   = '{8'd1, 8'd32, 8'd0, 8'd63, 8'd1, 8'hC5};
    ins_set = '{70, 45, 60, 30, 55, 40};
    rem_set = '{8, 25, 15, 35, 20, 30};
    x_set[4] = 8'($urandom_range(0, 255));
    y_set[4] = 8'($urandom_range(0, 255));
    w_set[4] = 8'($urandom_range(1, 32));

    repeat (12) @(posedge clk);
    rst_n <= 1'b1;

    // directed: empty table, absent remove, unknown request, extremes, duplicates
    send(REQ_QUERY, 9'd0, 8'd0, 8'd0, HEAD_ANY);
    send(REQ_REMOVE, 9'd5, 8'd0, 8'd0, HEAD_ANY);
    send(REQ_UNKNOWN, 9'h1FF, 8'hFF, 8'hFF, 3'd7);
    send(REQ_INSERT, 9'd0, 8'd0, 8'd0, HEAD_ANY);
    send(REQ_INSERT, 9'h1FF, 8'hFF, 8'hFF, 3'd7);
    send(REQ_INSERT, 9'd300, 8'd0, 8'd0, HEAD_ANY);
    send(REQ_INSERT, 9'd17, 8'd0, 8'd0, HEAD_ANY);
    send(REQ_INSERT, 9'd17, 8'd0, 8'd0, HEAD_ANY);
    send(REQ_INSERT, 9'd40, 8'd0, 8'd0, HEAD_ANY);
    for (int h = 0; h < 8; h++) begin
      send(REQ_QUERY, 9'd0, h[0] ? 8'hFF : 8'h00, h[1] ? 8'hFF : 8'h00, 3'(h));
    end
    send(REQ_QUERY, 9'd0, 8'd128, 8'd128, HEAD_UP);
    send(REQ_REMOVE, 9'd17, 8'd0, 8'd0, HEAD_ANY);
    send(REQ_REMOVE, 9'h1FF, 8'd0, 8'd0, HEAD_ANY);
    send(REQ_REMOVE, 9'd1, 8'd0, 8'd0, HEAD_ANY);
    send(REQ_QUERY, 9'd0, 8'd0, 8'hFF, HEAD_ANY);

    for (int ph = 0; ph < 6; ph++) begin
      set_config(x_set[ph], y_set[ph], w_set[ph]);
      gaps_on = (ph != 2);
      repeat (ITEMS_PER_SETTING) random_request(ins_set[ph], rem_set[ph]);
    end

    start <= 1'b0;
    @(posedge clk);
    while (results_owed != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (check_errors == 0 && results_owed == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule

// ----- directional_nearest_entry_search_top.f -----
rtl/dnes_pkg.sv
rtl/dnes_entry_mem.sv
rtl/dnes_divmod.sv
rtl/dnes_dist_pipe.sv
rtl/directional_nearest_entry_search_top.sv
dv/nearest_search_checker.sv
dv/tb.sv
